// ===== design/ffa_pkg.sv =====
// Package for the first-fit free-list allocator core.
// Holds beat types, request and status codes and fixed widths; depends on nothing.
package ffa_pkg;

   localparam int ADDR_W = 16;
   localparam int SIZE_W = 17;
   localparam int CNT_W  = 7;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_FREE  = 2'd1,
      REQ_RESET = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ZERO_SIZE = 3'd1,
      ST_BAD_ALIGN = 3'd2,
      ST_NO_FIT    = 3'd3,
      ST_BAD_FREE  = 3'd4,
      ST_LIVE_FULL = 3'd5
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_BYTES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARENA_ALIGN = 1'd1;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [SIZE_W-1:0] alloc_size;
      logic [3:0]        align_log2;
      logic [ADDR_W-1:0] free_address;
   } req_beat_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [ADDR_W-1:0] user_address;
      logic [SIZE_W-1:0] used_bytes;
      logic [SIZE_W-1:0] peak_bytes;
      logic [CNT_W-1:0]  free_extent_count;
      logic [SIZE_W-1:0] largest_free;
   } rsp_beat_type;

   // Classified command passed from the front end to the back end.
   typedef struct packed {
      req_kind_type      kind;
      status_type        early_status;
      logic [SIZE_W-1:0] alloc_size;
      logic [SIZE_W-1:0] eff_align;
      logic [ADDR_W-1:0] free_address;
   } cmd_type;

endpackage

// ===== design/first_fit_free_list_allocator_core.sv =====
// First-fit free-list allocator core: front end, command queue and table sequencer.
// Per beat: a walk of the live table (one entry a cycle) and of the extent table (a scan
// and an evaluate state an entry), plus shifts on remove or insert, and a pass over the
// extents for the largest size. One request is worked at a time.
// Reset is synchronous: one full extent, empty live table, zero used and peak bytes.
// The first extent is written in the cycle after reset, before any request is taken.
module first_fit_free_list_allocator_core
   import ffa_pkg::*;
#(
   parameter int ARENA_BYTES = 65536,
   parameter int MAX_LIVE = 64,
   parameter int HEADER_BYTES = 16,
   parameter int MIN_FREE_BYTES = 16,
   parameter int INTERNAL_ALIGN = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_beat_type         req_beat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_beat_type         rsp_beat,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_data
);

   logic [SIZE_W-1:0] arena_bytes_ff;
   logic [3:0]        arena_align_ff;
   logic              cmd_valid, cmd_ready;
   cmd_type           cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_bytes_ff <= SIZE_W'(65536);
         arena_align_ff <= 4'd12;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ARENA_BYTES: arena_bytes_ff <= csr_data;
            CSR_ARENA_ALIGN: arena_align_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   ffa_front #(.INTERNAL_ALIGN(INTERNAL_ALIGN), .DEPTH(2)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_beat(req_beat),
      .arena_align_log2(arena_align_ff),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
   );

   ffa_back #(
      .ARENA_BYTES(ARENA_BYTES), .MAX_LIVE(MAX_LIVE), .HEADER_BYTES(HEADER_BYTES),
      .MIN_FREE_BYTES(MIN_FREE_BYTES), .INTERNAL_ALIGN(INTERNAL_ALIGN)
   ) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
      .arena_bytes(arena_bytes_ff), .arena_align_log2(arena_align_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_beat(rsp_beat)
   );

endmodule

// ===== design/ffa_front.sv =====
// Front end: accepts request beats, checks size and alignment, queues commands.
// Depends on ffa_pkg.
module ffa_front
   import ffa_pkg::*;
#(
   parameter int INTERNAL_ALIGN = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_beat,
   input  logic [3:0]   arena_align_log2,
   output logic         cmd_valid,
   input  logic         cmd_ready,
   output cmd_type      cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type             q_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]      cnt_ff, cnt_in;
   cmd_type             c;
   logic [SIZE_W-1:0]   req_al, arena_al;
   logic                push, pop;

   always_comb begin
      req_al = SIZE_W'(1) << req_beat.align_log2;
      if (req_al < SIZE_W'(INTERNAL_ALIGN)) begin
         req_al = SIZE_W'(INTERNAL_ALIGN);
      end
      arena_al = SIZE_W'(1) << arena_align_log2;
      c.kind = req_kind_type'(req_beat.req_type);
      c.alloc_size = req_beat.alloc_size;
      c.eff_align = req_al;
      c.free_address = req_beat.free_address;
      c.early_status = ST_OK;
      if (c.kind == REQ_ALLOC) begin
         if (req_beat.alloc_size == '0) begin
            c.early_status = ST_ZERO_SIZE;
         end else if (req_al > arena_al) begin
            c.early_status = ST_BAD_ALIGN;
         end
      end
   end

   assign req_ready = (cnt_ff != (PTR_W+1)'(DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd = q_ff[rd_ff];
   assign push = req_valid && req_ready;
   assign pop = cmd_valid && cmd_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= c;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= (PTR_W+1)'(DEPTH))
      else $error("command queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("command queue count missed a push");
   assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd.kind == REQ_ALLOC && cmd.early_status == ST_OK |->
      cmd.alloc_size != '0)
      else $error("zero-size allocate passed as valid");

endmodule

// ===== design/ffa_back.sv =====
// Back end: sequencer over the extent and live tables, held in memories.
// Depends on ffa_pkg; driven by commands from ffa_front.
module ffa_back
   import ffa_pkg::*;
#(
   parameter int ARENA_BYTES = 65536,
   parameter int MAX_LIVE = 64,
   parameter int HEADER_BYTES = 16,
   parameter int MIN_FREE_BYTES = 16,
   parameter int INTERNAL_ALIGN = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  cmd_type           cmd,
   input  logic [SIZE_W-1:0] arena_bytes,
   input  logic [3:0]        arena_align_log2,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_beat_type      rsp_beat
);

   localparam int EXT_DEPTH = MAX_LIVE + 1;
   localparam int EI_W = $clog2(EXT_DEPTH + 1);
   localparam int LI_W = $clog2(MAX_LIVE);
   localparam int LC_W = $clog2(MAX_LIVE + 1);
   localparam int W = SIZE_W + 2;

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_LSCAN  = 15'b000000000000010,
      S_LREAD  = 15'b000000000000100,
      S_ESCAN  = 15'b000000000001000,
      S_EEVAL  = 15'b000000000010000,
      S_SHL    = 15'b000000000100000,
      S_SHL_W  = 15'b000000001000000,
      S_POS    = 15'b000000010000000,
      S_POSEV  = 15'b000000100000000,
      S_MERGE  = 15'b000001000000000,
      S_SHR    = 15'b000010000000000,
      S_SHR_W  = 15'b000100000000000,
      S_LARGE  = 15'b001000000000000,
      S_OUT    = 15'b010000000000000,
      S_LLAST  = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] ext_start_mem [EXT_DEPTH];
   logic [SIZE_W-1:0] ext_size_mem  [EXT_DEPTH];
   logic [ADDR_W-1:0] live_ua_mem   [MAX_LIVE];
   logic [ADDR_W-1:0] live_bs_mem   [MAX_LIVE];
   logic [SIZE_W-1:0] live_sz_mem   [MAX_LIVE];
   logic [MAX_LIVE-1:0] live_valid_ff;

   logic [EI_W-1:0] ext_cnt_ff, idx_ff, idx_in, lim_ff, lim_in;
   logic [LI_W-1:0] lidx_ff, lidx_in, slot_ff, slot_in;
   logic [LC_W-1:0] lcnt_ff, lcnt_in;
   logic [SIZE_W-1:0] used_ff, peak_ff, largest_ff, largest_in;
   logic [ADDR_W-1:0] rd_start_ff;
   logic [SIZE_W-1:0] rd_size_ff;
   logic [ADDR_W-1:0] rl_ua_ff, rl_bs_ff;
   logic [SIZE_W-1:0] rl_sz_ff;
   logic [ADDR_W-1:0] prev_start_ff, prev_start_in;
   logic [SIZE_W-1:0] prev_size_ff, prev_size_in;
   logic [ADDR_W-1:0] blk_start_ff, blk_start_in;
   logic [SIZE_W-1:0] blk_size_ff, blk_size_in;
   logic [ADDR_W-1:0] ua_ff, ua_in;
   status_type        status_ff, status_in;
   cmd_type           cmd_ff;
   logic              rsp_valid_ff;
   rsp_beat_type      rsp_ff;
   logic              init_ff;

   logic [EI_W-1:0] rd_addr;
   logic            ew_en;
   logic [EI_W-1:0] ew_addr;
   logic [ADDR_W-1:0] ew_start;
   logic [SIZE_W-1:0] ew_size;
   logic            lw_en;

   logic [W-1:0] bs_w, ua_w, tot_w, rest_w, amask, ea_w, arena_eff;
   logic [SIZE_W-1:0] arena_al;
   logic            mprev, mnext;

   assign arena_al = SIZE_W'(1) << arena_align_log2;
   always_comb begin
      arena_eff = (W'(arena_bytes) + W'(arena_al) - 1'b1) & ~(W'(arena_al) - 1'b1);
      if (arena_eff > W'(ARENA_BYTES)) begin
         arena_eff = W'(ARENA_BYTES);
      end
   end

   always_comb begin
      amask = W'(cmd_ff.eff_align) - 1'b1;
      bs_w = W'(rd_start_ff);
      ua_w = (bs_w + W'(HEADER_BYTES) + amask) & ~amask;
      tot_w = (ua_w - bs_w + W'(cmd_ff.alloc_size) + W'(INTERNAL_ALIGN - 1))
              & ~W'(INTERNAL_ALIGN - 1);
      rest_w = W'(rd_size_ff) - tot_w;
      ea_w = W'(prev_start_ff) + W'(prev_size_ff);
      mprev = (idx_ff != '0) && (ea_w == W'(blk_start_ff));
      mnext = (idx_ff < ext_cnt_ff) &&
              (W'(blk_start_ff) + W'(blk_size_ff) == W'(rd_start_ff));
   end

   always_ff @(posedge clock) begin
      rd_start_ff <= ext_start_mem[rd_addr];
      rd_size_ff <= ext_size_mem[rd_addr];
      rl_ua_ff <= live_ua_mem[lidx_ff];
      rl_bs_ff <= live_bs_mem[lidx_ff];
      rl_sz_ff <= live_sz_mem[lidx_ff];
      if (ew_en) begin
         ext_start_mem[ew_addr] <= ew_start;
         ext_size_mem[ew_addr] <= ew_size;
      end
      if (lw_en) begin
         live_ua_mem[slot_ff] <= ua_ff;
         live_bs_mem[slot_ff] <= blk_start_ff;
         live_sz_mem[slot_ff] <= blk_size_ff;
      end
   end

   assign cmd_ready = (state_ff == S_IDLE) && !init_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat = rsp_ff;

   logic [EI_W-1:0] ext_cnt_in;
   logic [SIZE_W-1:0] used_in, peak_in;
   logic [MAX_LIVE-1:0] live_valid_in;
   logic rsp_load;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      lim_in = lim_ff;
      lidx_in = lidx_ff;
      slot_in = slot_ff;
      lcnt_in = lcnt_ff;
      ext_cnt_in = ext_cnt_ff;
      used_in = used_ff;
      peak_in = peak_ff;
      live_valid_in = live_valid_ff;
      largest_in = largest_ff;
      prev_start_in = prev_start_ff;
      prev_size_in = prev_size_ff;
      blk_start_in = blk_start_ff;
      blk_size_in = blk_size_ff;
      ua_in = ua_ff;
      status_in = status_ff;
      rd_addr = idx_ff;
      ew_en = 1'b0;
      ew_addr = idx_ff;
      ew_start = rd_start_ff;
      ew_size = rd_size_ff;
      lw_en = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            lidx_in = '0;
            rd_addr = '0;
            ua_in = '0;
            if (init_ff) begin
               ew_en = 1'b1;
               ew_addr = '0;
               ew_start = '0;
               ew_size = SIZE_W'(arena_eff);
               ext_cnt_in = (arena_eff != '0) ? EI_W'(1) : '0;
            end else if (cmd_valid) begin
               status_in = cmd.early_status;
               priority if (cmd.kind == REQ_RESET) begin
                  ew_en = 1'b1;
                  ew_addr = '0;
                  ew_start = '0;
                  ew_size = SIZE_W'(arena_eff);
                  ext_cnt_in = (arena_eff != '0) ? EI_W'(1) : '0;
                  live_valid_in = '0;
                  lcnt_in = '0;
                  used_in = '0;
                  state_in = S_LARGE;
               end else if (cmd.kind == REQ_ALLOC && cmd.early_status == ST_OK) begin
                  if (lcnt_ff == LC_W'(MAX_LIVE)) begin
                     status_in = ST_LIVE_FULL;
                     state_in = S_LARGE;
                  end else begin
                     state_in = S_LSCAN;
                  end
               end else if (cmd.kind == REQ_FREE && cmd.free_address != '0) begin
                  state_in = S_LREAD;
               end else begin
                  state_in = S_LARGE;
               end
            end
         end
         S_LSCAN: begin
            rd_addr = '0;
            if (!live_valid_ff[lidx_ff]) begin
               slot_in = lidx_ff;
               state_in = S_ESCAN;
            end else begin
               lidx_in = lidx_ff + 1'b1;
            end
         end
         S_ESCAN: begin
            if (idx_ff >= ext_cnt_ff) begin
               status_in = ST_NO_FIT;
               state_in = S_LARGE;
               idx_in = '0;
            end else begin
               state_in = S_EEVAL;
            end
         end
         S_EEVAL: begin
            if (W'(rd_size_ff) < tot_w) begin
               idx_in = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
               state_in = S_ESCAN;
            end else begin
               ua_in = ADDR_W'(ua_w);
               blk_start_in = rd_start_ff;
               live_valid_in[slot_ff] = 1'b1;
               lcnt_in = lcnt_ff + 1'b1;
               if (rest_w >= W'(MIN_FREE_BYTES)) begin
                  blk_size_in = SIZE_W'(tot_w);
                  ew_en = 1'b1;
                  ew_start = ADDR_W'(bs_w + tot_w);
                  ew_size = SIZE_W'(rest_w);
                  used_in = used_ff + SIZE_W'(tot_w);
                  state_in = S_LARGE;
                  idx_in = '0;
               end else begin
                  blk_size_in = rd_size_ff;
                  used_in = used_ff + rd_size_ff;
                  ext_cnt_in = ext_cnt_ff - 1'b1;
                  lim_in = ext_cnt_ff - 1'b1;
                  rd_addr = idx_ff + 1'b1;
                  state_in = S_SHL;
               end
               if (used_in > peak_ff) begin
                  peak_in = used_in;
               end
               lw_en = 1'b0;
            end
         end
         S_SHL: begin
            if (idx_ff >= lim_ff) begin
               idx_in = '0;
               rd_addr = '0;
               state_in = S_LARGE;
            end else begin
               rd_addr = idx_ff + 1'b1;
               state_in = S_SHL_W;
            end
         end
         S_SHL_W: begin
            ew_en = 1'b1;
            ew_addr = idx_ff;
            idx_in = idx_ff + 1'b1;
            state_in = S_SHL;
         end
         S_LREAD: begin
            if (lidx_ff != '0 && live_valid_ff[lidx_ff - 1'b1] &&
                rl_ua_ff == cmd_ff.free_address) begin
               live_valid_in[lidx_ff - 1'b1] = 1'b0;
               lcnt_in = lcnt_ff - 1'b1;
               used_in = (used_ff >= rl_sz_ff) ? used_ff - rl_sz_ff : '0;
               blk_start_in = rl_bs_ff;
               blk_size_in = rl_sz_ff;
               rd_addr = '0;
               idx_in = '0;
               state_in = S_POS;
            end else if (lidx_ff == LI_W'(MAX_LIVE - 1)) begin
               state_in = S_LLAST;
            end else begin
               lidx_in = lidx_ff + 1'b1;
            end
         end
         S_LLAST: begin
            rd_addr = '0;
            idx_in = '0;
            if (live_valid_ff[lidx_ff] && rl_ua_ff == cmd_ff.free_address) begin
               live_valid_in[lidx_ff] = 1'b0;
               lcnt_in = lcnt_ff - 1'b1;
               used_in = (used_ff >= rl_sz_ff) ? used_ff - rl_sz_ff : '0;
               blk_start_in = rl_bs_ff;
               blk_size_in = rl_sz_ff;
               state_in = S_POS;
            end else begin
               status_in = ST_BAD_FREE;
               state_in = S_LARGE;
            end
         end
         S_POS: begin
            state_in = S_POSEV;
         end
         S_POSEV: begin
            if (idx_ff < ext_cnt_ff && rd_start_ff < blk_start_ff) begin
               prev_start_in = rd_start_ff;
               prev_size_in = rd_size_ff;
               idx_in = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
               state_in = S_POS;
            end else begin
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            priority if (mprev && mnext) begin
               ew_en = 1'b1;
               ew_addr = idx_ff - 1'b1;
               ew_start = prev_start_ff;
               ew_size = prev_size_ff + blk_size_ff + rd_size_ff;
               ext_cnt_in = ext_cnt_ff - 1'b1;
               lim_in = ext_cnt_ff - 1'b1;
               rd_addr = idx_ff + 1'b1;
               state_in = S_SHL;
            end else if (mprev) begin
               ew_en = 1'b1;
               ew_addr = idx_ff - 1'b1;
               ew_start = prev_start_ff;
               ew_size = prev_size_ff + blk_size_ff;
               state_in = S_LARGE;
               idx_in = '0;
            end else if (mnext) begin
               ew_en = 1'b1;
               ew_start = blk_start_ff;
               ew_size = rd_size_ff + blk_size_ff;
               state_in = S_LARGE;
               idx_in = '0;
            end else if (ext_cnt_ff < EI_W'(EXT_DEPTH)) begin
               lim_in = idx_ff;
               idx_in = ext_cnt_ff;
               ext_cnt_in = ext_cnt_ff + 1'b1;
               rd_addr = ext_cnt_ff - 1'b1;
               state_in = S_SHR;
            end else begin
               state_in = S_LARGE;
               idx_in = '0;
            end
         end
         S_SHR: begin
            if (idx_ff == lim_ff) begin
               ew_en = 1'b1;
               ew_start = blk_start_ff;
               ew_size = blk_size_ff;
               idx_in = '0;
               state_in = S_LARGE;
            end else begin
               rd_addr = idx_ff - 1'b1;
               state_in = S_SHR_W;
            end
         end
         S_SHR_W: begin
            ew_en = 1'b1;
            ew_addr = idx_ff;
            idx_in = idx_ff - 1'b1;
            state_in = S_SHR;
         end
         S_LARGE: begin
            lw_en = (status_ff == ST_OK) && (cmd_ff.kind == REQ_ALLOC);
            rd_addr = '0;
            largest_in = '0;
            idx_in = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (idx_ff < ext_cnt_ff && rd_size_ff > largest_ff) begin
               largest_in = rd_size_ff;
            end
            if (idx_ff >= ext_cnt_ff) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ext_cnt_ff <= EI_W'(1);
         live_valid_ff <= '0;
         lcnt_ff <= '0;
         used_ff <= '0;
         peak_ff <= '0;
         rsp_valid_ff <= 1'b0;
         init_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ext_cnt_ff <= ext_cnt_in;
         live_valid_ff <= live_valid_in;
         lcnt_ff <= lcnt_in;
         used_ff <= used_in;
         peak_ff <= peak_in;
         init_ff <= 1'b0;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      idx_ff <= idx_in;
      lim_ff <= lim_in;
      lidx_ff <= lidx_in;
      slot_ff <= slot_in;
      largest_ff <= largest_in;
      prev_start_ff <= prev_start_in;
      prev_size_ff <= prev_size_in;
      blk_start_ff <= blk_start_in;
      blk_size_ff <= blk_size_in;
      ua_ff <= ua_in;
      status_ff <= status_in;
      if (cmd_valid && cmd_ready) begin
         cmd_ff <= cmd;
      end
      if (rsp_load) begin
         rsp_ff.status <= status_ff;
         rsp_ff.user_address <= (status_ff == ST_OK) ? ua_ff : '0;
         rsp_ff.used_bytes <= used_ff;
         rsp_ff.peak_bytes <= peak_ff;
         rsp_ff.free_extent_count <= CNT_W'(ext_cnt_ff);
         rsp_ff.largest_free <= largest_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) ext_cnt_ff <= EI_W'(EXT_DEPTH))
      else $error("extent count beyond table depth");
   assert property (@(posedge clock) disable iff (reset) lcnt_ff <= LC_W'(MAX_LIVE))
      else $error("live count beyond table depth");
   assert property (@(posedge clock) disable iff (reset)
      lcnt_ff == LC_W'($countones(live_valid_ff)))
      else $error("live count disagrees with valid bits");
   assert property (@(posedge clock) disable iff (reset) used_ff <= peak_ff)
      else $error("used bytes above peak");

endmodule
